@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define AIEU_ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication, off while reset is high.
`define AIEU_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define AIEU_ASSERT_ALWAYS_NEXT(label, clk, pre, post) \
   label: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

@@ rtl/aieu_pkg.sv @@
`timescale 1ns / 1ps
package aieu_pkg;

   localparam int GPR_COUNT   = 31;
   localparam int GPR_IDX_W   = $clog2(GPR_COUNT);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [4:0] {
      CMD_NOP  = 5'd0,  CMD_BKPT = 5'd1,  CMD_BRK  = 5'd2,  CMD_MOV  = 5'd3,
      CMD_MOVN = 5'd4,  CMD_MOVK = 5'd5,  CMD_MOVW = 5'd6,  CMD_MOVT = 5'd7,
      CMD_ADD  = 5'd8,  CMD_ADDS = 5'd9,  CMD_SUB  = 5'd10, CMD_SUBS = 5'd11,
      CMD_AND  = 5'd12, CMD_ANDS = 5'd13, CMD_ORR  = 5'd14, CMD_EOR  = 5'd15,
      CMD_CMP  = 5'd16, CMD_TST  = 5'd17, CMD_B    = 5'd18, CMD_BL   = 5'd19,
      CMD_BR   = 5'd20, CMD_BX   = 5'd21, CMD_BLR  = 5'd22, CMD_RET  = 5'd23
   } cmd_type;

   typedef enum logic [3:0] {
      CC_EQ, CC_NE, CC_CS, CC_CC, CC_MI, CC_PL, CC_VS, CC_VC,
      CC_HI, CC_LS, CC_GE, CC_LT, CC_GT, CC_LE, CC_AL, CC_NV
   } cond_type;

   typedef enum logic [3:0] {
      OP_NOP, OP_BRK, OP_MOV, OP_MOVN, OP_MOVK, OP_MOVW, OP_MOVT,
      OP_ADD, OP_SUB, OP_AND, OP_ORR, OP_EOR, OP_JUMP, OP_LINK, OP_BAD
   } op_type;

   localparam logic [1:0] ISA_A32 = 2'd0;
   localparam logic [1:0] ISA_T32 = 2'd1;
   localparam logic [1:0] ISA_A64 = 2'd2;

   localparam logic [2:0] SHK_LSL = 3'd1;
   localparam logic [2:0] SHK_LSR = 3'd2;
   localparam logic [2:0] SHK_ASR = 3'd3;
   localparam logic [2:0] SHK_ROR = 3'd4;
   localparam logic [2:0] SHK_RRX = 3'd5;

   localparam logic [3:0] EXT_UXTB = 4'd1;
   localparam logic [3:0] EXT_UXTH = 4'd2;
   localparam logic [3:0] EXT_UXTW = 4'd3;
   localparam logic [3:0] EXT_SXTB = 4'd5;
   localparam logic [3:0] EXT_SXTH = 4'd6;
   localparam logic [3:0] EXT_SXTW = 4'd7;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_HALT = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   localparam logic [5:0] REG_A32_SP = 6'd13;
   localparam logic [5:0] REG_A32_LR = 6'd14;
   localparam logic [5:0] REG_A32_PC = 6'd15;
   localparam logic [5:0] REG_A64_LR = 6'd30;
   localparam logic [5:0] REG_SP     = 6'd31;

   typedef struct packed {
      op_type      op;
      logic        upd_flags;
      logic        wr_dest;
      logic        link_x30;
      cond_type    cond;
      logic        wide;
      logic [2:0]  instr_bytes;
      logic [5:0]  dest_reg;
      logic [5:0]  first_reg;
      logic [5:0]  second_reg;
      logic        use_imm;
      logic [63:0] imm_value;
      logic [2:0]  shift_kind;
      logic [5:0]  shamt;
      logic [3:0]  extend_kind;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

@@ rtl/aieu_front.sv @@
`timescale 1ns / 1ps
module aieu_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [4:0]           req_cmd,
   input  logic [3:0]           req_cond,
   input  logic                 req_wide,
   input  logic [2:0]           req_instr_bytes,
   input  logic [5:0]           req_dest_reg,
   input  logic [5:0]           req_first_reg,
   input  logic [5:0]           req_second_reg,
   input  logic                 req_use_imm,
   input  logic [63:0]          req_imm_value,
   input  logic [2:0]           req_shift_kind,
   input  logic [5:0]           req_shift_amount,
   input  logic [3:0]           req_extend_kind,
   input  logic                 pop,
   output aieu_pkg::head_type   head
);

   aieu_pkg::entry_type                 cls;
   aieu_pkg::entry_type                 q_ff [aieu_pkg::QUEUE_DEPTH];
   logic [aieu_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [aieu_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [aieu_pkg::QCNT_W-1:0]         count_ff, count_in;
   logic                                push;

   always_comb begin
      cls              = '0;
      cls.op           = aieu_pkg::OP_BAD;
      cls.cond         = aieu_pkg::cond_type'(req_cond);
      cls.wide         = req_wide;
      cls.instr_bytes  = req_instr_bytes;
      cls.dest_reg     = req_dest_reg;
      cls.first_reg    = req_first_reg;
      cls.second_reg   = req_second_reg;
      cls.use_imm      = req_use_imm;
      cls.imm_value    = req_imm_value;
      cls.shift_kind   = req_shift_kind;
      cls.shamt        = req_shift_amount;
      cls.extend_kind  = req_extend_kind;
      unique case (aieu_pkg::cmd_type'(req_cmd))
         aieu_pkg::CMD_NOP:  cls.op = aieu_pkg::OP_NOP;
         aieu_pkg::CMD_BKPT,
         aieu_pkg::CMD_BRK:  cls.op = aieu_pkg::OP_BRK;
         aieu_pkg::CMD_MOV:  begin cls.op = aieu_pkg::OP_MOV;  cls.wr_dest = 1'b1; end
         aieu_pkg::CMD_MOVN: begin cls.op = aieu_pkg::OP_MOVN; cls.wr_dest = 1'b1; end
         aieu_pkg::CMD_MOVK: begin cls.op = aieu_pkg::OP_MOVK; cls.wr_dest = 1'b1; end
         aieu_pkg::CMD_MOVW: begin cls.op = aieu_pkg::OP_MOVW; cls.wr_dest = 1'b1; end
         aieu_pkg::CMD_MOVT: begin cls.op = aieu_pkg::OP_MOVT; cls.wr_dest = 1'b1; end
         aieu_pkg::CMD_ADD:  begin cls.op = aieu_pkg::OP_ADD;  cls.wr_dest = 1'b1; end
         aieu_pkg::CMD_ADDS: begin
            cls.op = aieu_pkg::OP_ADD; cls.wr_dest = 1'b1; cls.upd_flags = 1'b1;
         end
         aieu_pkg::CMD_SUB:  begin cls.op = aieu_pkg::OP_SUB;  cls.wr_dest = 1'b1; end
         aieu_pkg::CMD_SUBS: begin
            cls.op = aieu_pkg::OP_SUB; cls.wr_dest = 1'b1; cls.upd_flags = 1'b1;
         end
         aieu_pkg::CMD_CMP:  begin cls.op = aieu_pkg::OP_SUB; cls.upd_flags = 1'b1; end
         aieu_pkg::CMD_AND:  begin cls.op = aieu_pkg::OP_AND;  cls.wr_dest = 1'b1; end
         aieu_pkg::CMD_ANDS: begin
            cls.op = aieu_pkg::OP_AND; cls.wr_dest = 1'b1; cls.upd_flags = 1'b1;
         end
         aieu_pkg::CMD_TST:  begin cls.op = aieu_pkg::OP_AND; cls.upd_flags = 1'b1; end
         aieu_pkg::CMD_ORR:  begin cls.op = aieu_pkg::OP_ORR;  cls.wr_dest = 1'b1; end
         aieu_pkg::CMD_EOR:  begin cls.op = aieu_pkg::OP_EOR;  cls.wr_dest = 1'b1; end
         aieu_pkg::CMD_B,
         aieu_pkg::CMD_BR,
         aieu_pkg::CMD_BX,
         aieu_pkg::CMD_RET:  cls.op = aieu_pkg::OP_JUMP;
         aieu_pkg::CMD_BL:   cls.op = aieu_pkg::OP_LINK;
         aieu_pkg::CMD_BLR:  begin cls.op = aieu_pkg::OP_LINK; cls.link_x30 = 1'b1; end
         default:            cls.op = aieu_pkg::OP_BAD;
      endcase
   end

   assign req_stall = (count_ff == aieu_pkg::QCNT_W'(aieu_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == aieu_pkg::QPTR_W'(aieu_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == aieu_pkg::QPTR_W'(aieu_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (!push && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= cls;
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = q_ff[rd_ptr_ff];

endmodule

@@ rtl/aieu_exec.sv @@
`timescale 1ns / 1ps
module aieu_exec (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [1:0]           csr_wr_data,
   input  aieu_pkg::head_type   head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic                 rsp_executed,
   output logic [63:0]          rsp_result_value,
   output logic [3:0]           rsp_flags_nzcv,
   output logic [63:0]          rsp_next_pc
);

   logic [63:0] gpr_ff [aieu_pkg::GPR_COUNT];
   logic [63:0] sp_ff;
   logic [63:0] pc_ff, pc_in;
   logic [3:0]  flags_ff, flags_in;
   logic [1:0]  isa_ff;
   logic        rsp_valid_ff;
   logic [1:0]  status_ff, status_in;
   logic        executed_ff, executed_in;
   logic [63:0] result_ff, result_in;

   aieu_pkg::entry_type e;
   logic        a64, fire, pass, fn, fz, fc, fv, big;
   logic [63:0] m, amask, seq, pc_read, left, old, src, ext, v, right, target;
   logic [63:0] lsl_r, lsr_r, asr_r, ror_r, rrx_r;
   logic [127:0] rot_w;
   logic [63:0]  rot_n;
   logic signed [63:0] asr_w;
   logic signed [31:0] asr_n;
   logic [4:0]  asr_amt_n;
   logic [64:0] sum;
   logic [63:0] diff, res, km;
   logic        sgn_a, sgn_b, sgn_r, c_add, v_add, c_sub, v_sub, res_n, res_z;
   logic        wr_en;
   logic [5:0]  wr_idx;
   logic [63:0] wr_val;

   function automatic logic [63:0] align(input logic [63:0] t, input logic [1:0] isa);
      return (isa == aieu_pkg::ISA_T32) ? (t & ~64'd1) : (t & ~64'd3);
   endfunction

   function automatic logic [63:0] read_raw(input logic [5:0] idx);
      logic [63:0] r;
      r = '0;
      if (idx == aieu_pkg::REG_SP || (!a64 && idx == aieu_pkg::REG_A32_SP)) r = sp_ff;
      else if (!a64 && idx == aieu_pkg::REG_A32_PC) r = pc_read;
      else if (idx < aieu_pkg::GPR_COUNT) r = gpr_ff[idx[aieu_pkg::GPR_IDX_W-1:0]];
      return r;
   endfunction

   assign e     = head.entry;
   assign a64   = isa_ff[1];
   assign fire  = head.valid && (!rsp_valid_ff || !rsp_stall);
   assign pop   = fire;
   assign m     = e.wide ? '1 : 64'h0000_0000_ffff_ffff;
   assign amask = a64 ? '1 : 64'h0000_0000_ffff_ffff;
   assign seq   = (pc_ff + 64'(e.instr_bytes)) & amask;
   assign pc_read = {32'd0, pc_ff[31:0] + ((isa_ff == aieu_pkg::ISA_A32) ? 32'd8 : 32'd4)};
   assign {fn, fz, fc, fv} = flags_ff;

   always_comb begin
      unique case (e.cond)
         aieu_pkg::CC_EQ: pass = fz;
         aieu_pkg::CC_NE: pass = !fz;
         aieu_pkg::CC_CS: pass = fc;
         aieu_pkg::CC_CC: pass = !fc;
         aieu_pkg::CC_MI: pass = fn;
         aieu_pkg::CC_PL: pass = !fn;
         aieu_pkg::CC_VS: pass = fv;
         aieu_pkg::CC_VC: pass = !fv;
         aieu_pkg::CC_HI: pass = fc && !fz;
         aieu_pkg::CC_LS: pass = !fc || fz;
         aieu_pkg::CC_GE: pass = (fn == fv);
         aieu_pkg::CC_LT: pass = (fn != fv);
         aieu_pkg::CC_GT: pass = !fz && (fn == fv);
         aieu_pkg::CC_LE: pass = fz || (fn != fv);
         aieu_pkg::CC_AL: pass = 1'b1;
         aieu_pkg::CC_NV: pass = 1'b0;
      endcase
   end

   // operand fetch and extend
   always_comb begin
      left   = read_raw(e.first_reg) & m;
      old    = read_raw(e.dest_reg) & m;
      target = e.use_imm ? e.imm_value : left;
      src    = read_raw(e.second_reg) & m;
      unique case (e.extend_kind)
         aieu_pkg::EXT_UXTB: ext = src & 64'hff;
         aieu_pkg::EXT_UXTH: ext = src & 64'hffff;
         aieu_pkg::EXT_UXTW: ext = src & 64'hffff_ffff;
         aieu_pkg::EXT_SXTB: ext = {{56{src[7]}}, src[7:0]};
         aieu_pkg::EXT_SXTH: ext = {{48{src[15]}}, src[15:0]};
         aieu_pkg::EXT_SXTW: ext = {{32{src[31]}}, src[31:0]};
         default:            ext = src;
      endcase
      v = (e.use_imm ? e.imm_value : ext) & m;
   end

   // second-operand shifter
   always_comb begin
      big       = !e.wide && e.shamt[5];
      lsl_r     = big ? '0 : ((v << e.shamt) & m);
      lsr_r     = big ? '0 : (v >> e.shamt);
      asr_w     = $signed(v) >>> e.shamt;
      asr_amt_n = e.shamt[5] ? 5'd31 : e.shamt[4:0];
      asr_n     = $signed(v[31:0]) >>> asr_amt_n;
      asr_r     = e.wide ? 64'(asr_w) : {32'd0, 32'(asr_n)};
      rot_w     = {v, v} >> e.shamt;
      rot_n     = {v[31:0], v[31:0]} >> e.shamt[4:0];
      ror_r     = e.wide ? rot_w[63:0] : {32'd0, rot_n[31:0]};
      rrx_r     = e.wide ? {fc, v[63:1]} : {32'd0, fc, v[31:1]};
      if (e.shamt == '0) begin
         right = v;
      end else begin
         unique case (e.shift_kind)
            aieu_pkg::SHK_LSL: right = lsl_r;
            aieu_pkg::SHK_LSR: right = lsr_r;
            aieu_pkg::SHK_ASR: right = asr_r;
            aieu_pkg::SHK_ROR: right = ror_r;
            aieu_pkg::SHK_RRX: right = rrx_r;
            default:           right = v;
         endcase
      end
   end

   // adder, subtractor and flag terms
   always_comb begin
      sum   = {1'b0, left} + {1'b0, right};
      diff  = left - right;
      sgn_a = e.wide ? left[63] : left[31];
      sgn_b = e.wide ? right[63] : right[31];
      c_add = e.wide ? sum[64] : sum[32];
      c_sub = (left >= right);
      sgn_r = e.wide ? sum[63] : sum[31];
      v_add = (sgn_a == sgn_b) && (sgn_a != sgn_r);
      v_sub = (sgn_a != sgn_b) && (sgn_a != (e.wide ? diff[63] : diff[31]));
      km    = 64'hffff << e.shamt;
   end

   always_comb begin
      status_in   = aieu_pkg::ST_OK;
      executed_in = 1'b0;
      res         = '0;
      res_n       = 1'b0;
      res_z       = 1'b0;
      flags_in    = flags_ff;
      pc_in       = seq;
      wr_en       = 1'b0;
      wr_idx      = e.dest_reg;
      wr_val      = '0;
      if (pass && e.op == aieu_pkg::OP_BAD) begin
         status_in = aieu_pkg::ST_BAD;
         pc_in     = pc_ff;
      end else if (pass) begin
         executed_in = 1'b1;
         unique case (e.op)
            aieu_pkg::OP_BRK:  status_in = aieu_pkg::ST_HALT;
            aieu_pkg::OP_MOV:  res = right;
            aieu_pkg::OP_MOVN: res = ~right & m;
            aieu_pkg::OP_MOVK: res = ((old & ~km) | ({48'd0, e.imm_value[15:0]} << e.shamt))
                                     & m;
            aieu_pkg::OP_MOVW: res = {48'd0, e.imm_value[15:0]} & m;
            aieu_pkg::OP_MOVT: res = ({48'd0, old[15:0]} | {32'd0, e.imm_value[15:0], 16'd0}) & m;
            aieu_pkg::OP_ADD:  res = sum[63:0] & m;
            aieu_pkg::OP_SUB:  res = diff & m;
            aieu_pkg::OP_AND:  res = left & right;
            aieu_pkg::OP_ORR:  res = left | right;
            aieu_pkg::OP_EOR:  res = left ^ right;
            aieu_pkg::OP_JUMP: pc_in = align(target, isa_ff);
            aieu_pkg::OP_LINK: begin
               res    = seq;
               wr_en  = 1'b1;
               wr_idx = (e.link_x30 || a64) ? aieu_pkg::REG_A64_LR : aieu_pkg::REG_A32_LR;
               wr_val = seq;
               pc_in  = align(target, isa_ff);
            end
            default: ;
         endcase
         res_n = e.wide ? res[63] : res[31];
         res_z = (res == '0);
         if (e.upd_flags) begin
            unique case (e.op)
               aieu_pkg::OP_ADD: flags_in = {res_n, res_z, c_add, v_add};
               aieu_pkg::OP_SUB: flags_in = {res_n, res_z, c_sub, v_sub};
               default:          flags_in = {res_n, res_z, 2'b00};
            endcase
         end
         if (e.wr_dest) begin
            wr_en  = 1'b1;
            wr_val = res;
            // a write to the A32/T32 PC register branches
            if (!a64 && e.dest_reg == aieu_pkg::REG_A32_PC) pc_in = align(res, isa_ff);
         end
      end
      result_in = res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         isa_ff       <= aieu_pkg::ISA_A64;
         flags_ff     <= '0;
         pc_ff        <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < aieu_pkg::GPR_COUNT; i++) gpr_ff[i] <= '0;
      end else begin
         if (csr_wr_en) isa_ff <= csr_wr_data;
         if (fire) begin
            pc_ff    <= pc_in;
            flags_ff <= flags_in;
            if (wr_en) begin
               if (wr_idx == aieu_pkg::REG_SP || (!a64 && wr_idx == aieu_pkg::REG_A32_SP)) begin
                  sp_ff <= wr_val;
               end else if (!a64 && wr_idx == aieu_pkg::REG_A32_PC) begin
                  sp_ff <= sp_ff;
               end else if (wr_idx < aieu_pkg::GPR_COUNT) begin
                  gpr_ff[wr_idx[aieu_pkg::GPR_IDX_W-1:0]] <= wr_val;
               end
            end
         end
         if (fire) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff   <= status_in;
         executed_ff <= executed_in;
         result_ff   <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_executed     = executed_ff;
   assign rsp_result_value = result_ff;
   assign rsp_flags_nzcv   = flags_ff;
   assign rsp_next_pc      = pc_ff;

endmodule

@@ rtl/arm_integer_execute_unit_core.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  decoded instruction fields
// rsp_      out        rsp_valid/rsp_stall  status, executed, result, NZCV, next PC
// csr_      in         csr_wr_en            isa_mode (2 bits)
//
// One request per cycle sustained while rsp_stall is low; the response follows acceptance
// through the queue slot, then the execute stage with its output register.
// The execute stage retires one instruction per cycle unless stalled: register read, one shift, one add.
// Synchronous active-high reset clears registers, SP, PC, flags, sets A64 mode.
// A two-entry queue lets requests keep arriving while rsp_stall holds the output.
module arm_integer_execute_unit_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_cmd,
   input  logic [3:0]  req_cond,
   input  logic        req_wide,
   input  logic [2:0]  req_instr_bytes,
   input  logic [5:0]  req_dest_reg,
   input  logic [5:0]  req_first_reg,
   input  logic [5:0]  req_second_reg,
   input  logic        req_use_imm,
   input  logic [63:0] req_imm_value,
   input  logic [2:0]  req_shift_kind,
   input  logic [5:0]  req_shift_amount,
   input  logic [3:0]  req_extend_kind,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_executed,
   output logic [63:0] rsp_result_value,
   output logic [3:0]  rsp_flags_nzcv,
   output logic [63:0] rsp_next_pc,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);

   aieu_pkg::head_type head;
   logic               pop;

   aieu_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_cond         (req_cond),
      .req_wide         (req_wide),
      .req_instr_bytes  (req_instr_bytes),
      .req_dest_reg     (req_dest_reg),
      .req_first_reg    (req_first_reg),
      .req_second_reg   (req_second_reg),
      .req_use_imm      (req_use_imm),
      .req_imm_value    (req_imm_value),
      .req_shift_kind   (req_shift_kind),
      .req_shift_amount (req_shift_amount),
      .req_extend_kind  (req_extend_kind),
      .pop              (pop),
      .head             (head)
   );

   aieu_exec u_exec (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_executed     (rsp_executed),
      .rsp_result_value (rsp_result_value),
      .rsp_flags_nzcv   (rsp_flags_nzcv),
      .rsp_next_pc      (rsp_next_pc)
   );

endmodule

@@ rtl/aieu_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aieu_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic        rsp_executed,
   input logic [63:0] rsp_result_value,
   input logic [63:0] rsp_next_pc
);

   `AIEU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_next_pc) && $stable(rsp_result_value))
   `AIEU_ASSERT_IMPLIES(a_bad_quiet, clock, reset, rsp_valid && rsp_status == aieu_pkg::ST_BAD, !rsp_executed && rsp_result_value == '0)
   `AIEU_ASSERT_IMPLIES(a_halt_ran, clock, reset, rsp_valid && rsp_status == aieu_pkg::ST_HALT, rsp_executed && rsp_result_value == '0)
   `AIEU_ASSERT_IMPLIES(a_skip_zero, clock, reset, rsp_valid && !rsp_executed, rsp_result_value == '0)
   `AIEU_ASSERT_ALWAYS_NEXT(a_reset_idle, clock, reset, !rsp_valid)

endmodule

bind arm_integer_execute_unit_core aieu_port_checks u_aieu_port_checks (.*);
